@@ rtl/i2cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared types, codes and constants for the tick-driven I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // Default width of the tick delay counter.
  localparam int unsigned DelayWidthDef = 16;

  // Widths of the configuration registers and the write port.
  localparam int unsigned TickWidth  = 16;
  localparam int unsigned RetryWidth = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETUP       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_RETRIES = 2'd2;

  // Register reset values.
  localparam logic [TickWidth-1:0]  HalfPeriodRst = 16'd5;
  localparam logic [TickWidth-1:0]  SetupRst      = 16'd1;
  localparam logic [RetryWidth-1:0] AckRetriesRst = 8'd10;

  // Command codes.
  localparam logic [2:0] FUNC_START    = 3'd0;
  localparam logic [2:0] FUNC_STOP     = 3'd1;
  localparam logic [2:0] FUNC_WRITE    = 3'd2;
  localparam logic [2:0] FUNC_READ     = 3'd3;
  localparam logic [2:0] FUNC_SEND_ACK = 3'd4;
  localparam logic [2:0] FUNC_WAIT_ACK = 3'd5;

  // Stream widths.
  localparam int unsigned SDataW = 16;
  localparam int unsigned SUserW = 4;
  localparam int unsigned MDataW = 16;

  // Bus sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST_A     = 5'd1,
    PH_ST_B     = 5'd2,
    PH_ST_C     = 5'd3,
    PH_ST_D     = 5'd4,
    PH_SP_A     = 5'd5,
    PH_SP_B     = 5'd6,
    PH_SP_C     = 5'd7,
    PH_AK_A     = 5'd8,
    PH_AK_B     = 5'd9,
    PH_WR_SETUP = 5'd10,
    PH_WR_HIGH  = 5'd11,
    PH_WR_LOW   = 5'd12,
    PH_RD_LOW   = 5'd13,
    PH_RD_HIGH  = 5'd14,
    PH_RD_HOLD  = 5'd15,
    PH_WA_LOW   = 5'd16,
    PH_WA_HIGH  = 5'd17,
    PH_WA_POLL  = 5'd18
  } phase_e;

  // Configuration register values as seen by the sequencer.
  typedef struct packed {
    logic [TickWidth-1:0]  half_period_ticks;
    logic [TickWidth-1:0]  setup_ticks;
    logic [RetryWidth-1:0] ack_retries;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic       nack;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_enable;
    logic       sda_out;
    logic       scl_level;
  } res_t;

endpackage

@@ rtl/i2c_bit_level_master.sv @@
// ----------------------------------------------------------------------------
// I2C bit-level master
// Path: a tick beat moves from the input register into the result register
// once the result register is free or draining.
// Throughput: one tick beat per clock cycle unless the result side stalls;
// the sequencer update is a single registered step between the two registers.
// Reset: asynchronous, active low; bus idle with both lines driven high and
// configuration registers at their defaults.
// ----------------------------------------------------------------------------
module i2c_bit_level_master import i2cbm_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = DelayWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Tick input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tx_byte[7:0], ack_level[8], sda_level[9], zero fill [15:10]
  input  logic [SDataW-1:0]   s_axis_tdata,
  // cmd_valid[0], func[3:1]
  input  logic [SUserW-1:0]   s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scl_level[0], sda_out[1], sda_enable[2], busy_res[3], done_res[4],
  // rx_byte[12:5], nack[13], zero fill [15:14]
  output logic [MDataW-1:0]   m_axis_tdata
);

  cfg_t       cfg;
  res_t       res;
  logic       step;
  logic       in_vld_q;
  logic       cmd_valid_q;
  logic [2:0] func_q;
  logic [7:0] tx_byte_q;
  logic       ack_level_q;
  logic       sda_level_q;
  logic       out_vld_q;
  res_t       res_q;

  i2cbm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // A held tick beat advances when the result register is free or draining.
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_valid_q <= s_axis_tuser[0];
      func_q      <= s_axis_tuser[3:1];
      tx_byte_q   <= s_axis_tdata[7:0];
      ack_level_q <= s_axis_tdata[8];
      sda_level_q <= s_axis_tdata[9];
    end
  end

  i2cbm_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid_q),
    .func_i      (func_q),
    .tx_byte_i   (tx_byte_q),
    .ack_level_i (ack_level_q),
    .sda_level_i (sda_level_q),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q};

endmodule

@@ rtl/i2cbm_cfg.sv @@
// ----------------------------------------------------------------------------
// I2C bit-level master configuration registers
// Holds the tick counts and the ack retry limit written over the config port.
// ----------------------------------------------------------------------------
module i2cbm_cfg import i2cbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HalfPeriodRst;
      cfg_q.setup_ticks       <= SetupRst;
      cfg_q.ack_retries       <= AckRetriesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_wdata_i[TickWidth-1:0];
        CFG_SETUP:       cfg_q.setup_ticks       <= cfg_wdata_i[TickWidth-1:0];
        CFG_ACK_RETRIES: cfg_q.ack_retries       <= cfg_wdata_i[RetryWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/i2cbm_core.sv @@
// ----------------------------------------------------------------------------
// I2C bit-level master sequencer
// Bus phase state machine; advances by one tick whenever step_i is high and
// presents the line levels and status after that tick.
// ----------------------------------------------------------------------------
module i2cbm_core import i2cbm_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = DelayWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  cfg_t       cfg_i,
  input  logic       cmd_valid_i,
  input  logic [2:0] func_i,
  input  logic [7:0] tx_byte_i,
  input  logic       ack_level_i,
  input  logic       sda_level_i,
  output res_t       res_o
);

  phase_e                 phase_q, phase_d;
  logic [DELAY_WIDTH-1:0] delay_q, delay_d;
  logic [3:0]             bit_q, bit_d;
  logic [3:0]             bit_inc;
  logic [7:0]             shift_q, shift_d;
  logic [RetryWidth-1:0]  retry_q, retry_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   en_q, en_d;
  logic [7:0]             rx_q, rx_d;
  logic                   nack_q, nack_d;
  logic                   tmo_q, tmo_d;
  logic                   done;

  // Tick count cut to the counter width; zero counts as one.
  function automatic logic [DELAY_WIDTH-1:0] load_ticks(logic [TickWidth-1:0] ticks);
    logic [31:0]            ext;
    logic [DELAY_WIDTH-1:0] v;
    ext = 32'(ticks);
    v   = ext[DELAY_WIDTH-1:0];
    if (v == '0) begin
      v = DELAY_WIDTH'(1);
    end
    return v;
  endfunction

  assign bit_inc = bit_q + 4'd1;

  // Next state for one tick.
  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    retry_d = retry_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    en_d    = en_q;
    rx_d    = rx_q;
    nack_d  = nack_q;
    tmo_d   = tmo_q;
    done    = 1'b0;

    if (phase_q == PH_IDLE) begin
      // Launch a new command; unknown codes are ignored.
      if (cmd_valid_i) begin
        unique case (func_i)
          FUNC_START: begin
            tmo_d   = 1'b0;
            en_d    = 1'b1;
            sda_d   = 1'b1;
            phase_d = PH_ST_A;
            delay_d = load_ticks(cfg_i.half_period_ticks);
          end
          FUNC_STOP: begin
            tmo_d   = 1'b0;
            en_d    = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_SP_A;
            delay_d = DELAY_WIDTH'(1);
          end
          FUNC_WRITE: begin
            tmo_d   = 1'b0;
            shift_d = tx_byte_i;
            bit_d   = 4'd0;
            en_d    = 1'b1;
            scl_d   = 1'b0;
            sda_d   = tx_byte_i[7];
            phase_d = PH_WR_SETUP;
            delay_d = load_ticks(cfg_i.setup_ticks);
          end
          FUNC_READ: begin
            tmo_d   = 1'b0;
            shift_d = 8'd0;
            bit_d   = 4'd0;
            en_d    = 1'b0;
            scl_d   = 1'b0;
            phase_d = PH_RD_LOW;
            delay_d = load_ticks(cfg_i.half_period_ticks);
          end
          FUNC_SEND_ACK: begin
            tmo_d   = 1'b0;
            shift_d = {7'd0, ack_level_i};
            en_d    = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_AK_A;
            delay_d = load_ticks(cfg_i.half_period_ticks);
          end
          FUNC_WAIT_ACK: begin
            tmo_d   = 1'b0;
            retry_d = cfg_i.ack_retries;
            scl_d   = 1'b0;
            sda_d   = 1'b1;
            en_d    = 1'b0;
            phase_d = PH_WA_LOW;
            delay_d = load_ticks(cfg_i.half_period_ticks);
          end
          default: ;
        endcase
      end
    end else if (delay_q > DELAY_WIDTH'(1)) begin
      // Hold the current line levels.
      delay_d = delay_q - DELAY_WIDTH'(1);
    end else begin
      // Delay expired: move to the next phase.
      unique case (phase_q)
        PH_ST_A: begin
          scl_d   = 1'b1;
          phase_d = PH_ST_B;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_ST_B: begin
          sda_d   = 1'b0;
          phase_d = PH_ST_C;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_ST_C: begin
          scl_d   = 1'b0;
          phase_d = PH_ST_D;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_SP_A: begin
          scl_d   = 1'b1;
          phase_d = PH_SP_B;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_SP_B: begin
          sda_d   = 1'b1;
          phase_d = PH_SP_C;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_SP_C: begin
          // A stop that closes an ack timeout reports nack.
          if (tmo_q) begin
            nack_d = 1'b1;
            tmo_d  = 1'b0;
          end
          phase_d = PH_IDLE;
          delay_d = '0;
          done    = 1'b1;
        end
        PH_AK_A: begin
          sda_d   = shift_q[0];
          scl_d   = 1'b1;
          phase_d = PH_AK_B;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_AK_B: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          phase_d = PH_IDLE;
          delay_d = '0;
          done    = 1'b1;
        end
        PH_WR_SETUP: begin
          scl_d   = 1'b1;
          phase_d = PH_WR_HIGH;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_WR_HIGH: begin
          scl_d   = 1'b0;
          phase_d = PH_WR_LOW;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_WR_LOW: begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc;
          if (bit_inc >= 4'd8) begin
            phase_d = PH_IDLE;
            delay_d = '0;
            done    = 1'b1;
          end else begin
            sda_d   = shift_q[6];
            phase_d = PH_WR_SETUP;
            delay_d = load_ticks(cfg_i.setup_ticks);
          end
        end
        PH_RD_LOW: begin
          scl_d   = 1'b1;
          phase_d = PH_RD_HIGH;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_RD_HIGH: begin
          shift_d = {shift_q[6:0], sda_level_i};
          phase_d = PH_RD_HOLD;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_RD_HOLD: begin
          bit_d = bit_inc;
          scl_d = 1'b0;
          if (bit_inc >= 4'd8) begin
            rx_d    = shift_q;
            phase_d = PH_IDLE;
            delay_d = '0;
            done    = 1'b1;
          end else begin
            phase_d = PH_RD_LOW;
            delay_d = load_ticks(cfg_i.half_period_ticks);
          end
        end
        PH_WA_LOW: begin
          scl_d   = 1'b1;
          phase_d = PH_WA_HIGH;
          delay_d = load_ticks(cfg_i.half_period_ticks);
        end
        PH_WA_HIGH, PH_WA_POLL: begin
          // Poll the data line for an ack.
          if (retry_q == '0) begin
            tmo_d   = 1'b1;
            en_d    = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_SP_A;
            delay_d = DELAY_WIDTH'(1);
          end else if (!sda_level_i) begin
            scl_d   = 1'b0;
            en_d    = 1'b1;
            nack_d  = 1'b0;
            phase_d = PH_IDLE;
            delay_d = '0;
            done    = 1'b1;
          end else begin
            retry_d = retry_q - RetryWidth'(1);
            phase_d = PH_WA_POLL;
            delay_d = load_ticks(cfg_i.half_period_ticks);
          end
        end
        default: begin
          phase_d = PH_IDLE;
          delay_d = '0;
          done    = 1'b1;
        end
      endcase
    end
  end

  // State registers, updated once per tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      delay_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      retry_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      en_q    <= 1'b1;
      rx_q    <= '0;
      nack_q  <= 1'b0;
      tmo_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      retry_q <= retry_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      en_q    <= en_d;
      rx_q    <= rx_d;
      nack_q  <= nack_d;
      tmo_q   <= tmo_d;
    end
  end

  // Result of this tick: line and status values after the update.
  assign res_o.scl_level  = scl_d;
  assign res_o.sda_out    = sda_d;
  assign res_o.sda_enable = en_d;
  assign res_o.busy_res   = (phase_d != PH_IDLE);
  assign res_o.done_res   = done;
  assign res_o.rx_byte    = rx_d;
  assign res_o.nack       = nack_d;

endmodule

@@ tb/i2c_bit_level_master_chk.sv @@
// ----------------------------------------------------------------------------
// I2C bit-level master line checker
// Watches the configuration port and both streams of the bit-level master.
// Every accepted tick beat is run through a cycle-true model of the bus
// sequencer, and the line state it predicts is queued. Each result beat is
// then compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_chk import i2cbm_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = DelayWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // tx_byte[7:0], ack_level[8], sda_level[9], zero fill [15:10]
  input  logic [SDataW-1:0]   s_axis_tdata,
  // cmd_valid[0], func[3:1]
  input  logic [SUserW-1:0]   s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scl_level[0], sda_out[1], sda_enable[2], busy_res[3], done_res[4],
  // rx_byte[12:5], nack[13], zero fill [15:14]
  input  logic [MDataW-1:0]   m_axis_tdata,
  output int                  mismatch_cnt_o,
  output int                  lines_pending_o,
  output logic                seq_busy_o
);

  // Shadow copy of the configuration registers.
  logic [TickWidth-1:0]   half_ticks;
  logic [TickWidth-1:0]   setup_ticks;
  logic [RetryWidth-1:0]  retry_limit;

  // Shadow copy of the sequencer.
  phase_e                 phase;
  logic [DELAY_WIDTH-1:0] dly_cnt;
  logic [3:0]             bit_cnt;
  logic [7:0]             shreg;
  logic [7:0]             polls_left;
  logic                   scl_q;
  logic                   sda_q;
  logic                   sda_en_q;
  logic [7:0]             rx_hold;
  logic                   nack_hold;
  logic                   done_q;
  logic                   timeout_pending;

  res_t                   line_exp_q[$];
  res_t                   exp_r;
  res_t                   got_r;

  initial mismatch_cnt_o = 0;

  assign seq_busy_o = (phase != PH_IDLE);

  // A tick count whose low DELAY_WIDTH bits are all zero behaves as one.
  function automatic void enter_phase(input phase_e ph, input logic [TickWidth-1:0] ticks);
    logic [DELAY_WIDTH-1:0] v;
    v = DELAY_WIDTH'(ticks);
    if (v == '0) begin
      v = DELAY_WIDTH'(1);
    end
    phase   = ph;
    dly_cnt = v;
  endfunction

  function automatic void finish_cmd();
    phase   = PH_IDLE;
    dly_cnt = '0;
    done_q  = 1'b1;
  endfunction

  function automatic void enter_stop();
    sda_en_q = 1'b1;
    scl_q    = 1'b0;
    sda_q    = 1'b0;
    enter_phase(PH_SP_A, TickWidth'(1));
  endfunction

  // Advances the sequencer by one tick and returns the line state after it.
  function automatic res_t predict_lines(input logic cmd_valid, input logic [2:0] func,
                                         input logic [7:0] tx, input logic ack_lvl,
                                         input logic sda_in);
    res_t r;
    done_q = 1'b0;
    if (phase == PH_IDLE) begin
      // Only a known command leaves idle; anything else is ignored.
      if (cmd_valid && func <= FUNC_WAIT_ACK) begin
        timeout_pending = 1'b0;
        case (func)
          FUNC_START: begin
            sda_en_q = 1'b1;
            sda_q    = 1'b1;
            enter_phase(PH_ST_A, half_ticks);
          end
          FUNC_STOP: begin
            enter_stop();
          end
          FUNC_WRITE: begin
            shreg    = tx;
            bit_cnt  = '0;
            sda_en_q = 1'b1;
            scl_q    = 1'b0;
            sda_q    = tx[7];
            enter_phase(PH_WR_SETUP, setup_ticks);
          end
          FUNC_READ: begin
            shreg    = '0;
            bit_cnt  = '0;
            sda_en_q = 1'b0;
            scl_q    = 1'b0;
            enter_phase(PH_RD_LOW, half_ticks);
          end
          FUNC_SEND_ACK: begin
            // The ack level is latched here, later ticks do not matter.
            shreg    = {7'd0, ack_lvl};
            sda_en_q = 1'b1;
            scl_q    = 1'b0;
            sda_q    = 1'b0;
            enter_phase(PH_AK_A, half_ticks);
          end
          default: begin
            polls_left = retry_limit;
            scl_q      = 1'b0;
            sda_q      = 1'b1;
            sda_en_q   = 1'b0;
            enter_phase(PH_WA_LOW, half_ticks);
          end
        endcase
      end
    end else if (dly_cnt > 1) begin
      dly_cnt = dly_cnt - 1'b1;
    end else begin
      case (phase)
        PH_ST_A: begin scl_q = 1'b1; enter_phase(PH_ST_B, half_ticks); end
        PH_ST_B: begin sda_q = 1'b0; enter_phase(PH_ST_C, half_ticks); end
        PH_ST_C: begin scl_q = 1'b0; enter_phase(PH_ST_D, half_ticks); end
        PH_SP_A: begin scl_q = 1'b1; enter_phase(PH_SP_B, half_ticks); end
        PH_SP_B: begin sda_q = 1'b1; enter_phase(PH_SP_C, half_ticks); end
        PH_SP_C: begin
          // A stop issued by an ack timeout reports nack once it completes.
          if (timeout_pending) begin
            nack_hold       = 1'b1;
            timeout_pending = 1'b0;
          end
          finish_cmd();
        end
        PH_AK_A: begin
          sda_q = shreg[0];
          scl_q = 1'b1;
          enter_phase(PH_AK_B, half_ticks);
        end
        PH_AK_B: begin scl_q = 1'b0; sda_q = 1'b1; finish_cmd(); end
        PH_WR_SETUP: begin scl_q = 1'b1; enter_phase(PH_WR_HIGH, half_ticks); end
        PH_WR_HIGH: begin scl_q = 1'b0; enter_phase(PH_WR_LOW, half_ticks); end
        PH_WR_LOW: begin
          shreg   = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt >= 8) begin
            finish_cmd();
          end else begin
            sda_q = shreg[7];
            enter_phase(PH_WR_SETUP, setup_ticks);
          end
        end
        PH_RD_LOW: begin scl_q = 1'b1; enter_phase(PH_RD_HIGH, half_ticks); end
        PH_RD_HIGH: begin
          shreg = {shreg[6:0], sda_in};
          enter_phase(PH_RD_HOLD, half_ticks);
        end
        PH_RD_HOLD: begin
          bit_cnt = bit_cnt + 1'b1;
          scl_q   = 1'b0;
          if (bit_cnt >= 8) begin
            rx_hold = shreg;
            finish_cmd();
          end else begin
            enter_phase(PH_RD_LOW, half_ticks);
          end
        end
        PH_WA_LOW: begin scl_q = 1'b1; enter_phase(PH_WA_HIGH, half_ticks); end
        PH_WA_HIGH, PH_WA_POLL: begin
          // Out of polls: stop on our own; a low line is an ack; else retry.
          if (polls_left == 0) begin
            timeout_pending = 1'b1;
            enter_stop();
          end else if (!sda_in) begin
            scl_q     = 1'b0;
            sda_en_q  = 1'b1;
            nack_hold = 1'b0;
            finish_cmd();
          end else begin
            polls_left = polls_left - 1'b1;
            enter_phase(PH_WA_POLL, half_ticks);
          end
        end
        default: begin
          finish_cmd();
        end
      endcase
    end
    r.scl_level  = scl_q;
    r.sda_out    = sda_q;
    r.sda_enable = sda_en_q;
    r.busy_res   = (phase != PH_IDLE);
    r.done_res   = done_q;
    r.rx_byte    = rx_hold;
    r.nack       = nack_hold;
    return r;
  endfunction

  task automatic check_field(input string fld, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      mismatch_cnt_o++;
    end
  endtask

  // Sample every channel at the rising edge: configuration, ticks, results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_ticks      = HalfPeriodRst;
      setup_ticks     = SetupRst;
      retry_limit     = AckRetriesRst;
      phase           = PH_IDLE;
      dly_cnt         = '0;
      bit_cnt         = '0;
      shreg           = '0;
      polls_left      = '0;
      scl_q           = 1'b1;
      sda_q           = 1'b1;
      sda_en_q        = 1'b1;
      rx_hold         = '0;
      nack_hold       = 1'b0;
      done_q          = 1'b0;
      timeout_pending = 1'b0;
      line_exp_q.delete();
      lines_pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HALF_PERIOD: half_ticks  = cfg_wdata_i[TickWidth-1:0];
          CFG_SETUP:       setup_ticks = cfg_wdata_i[TickWidth-1:0];
          CFG_ACK_RETRIES: retry_limit = cfg_wdata_i[RetryWidth-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        line_exp_q.push_back(predict_lines(s_axis_tuser[0], s_axis_tuser[3:1],
                                           s_axis_tdata[7:0], s_axis_tdata[8],
                                           s_axis_tdata[9]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
        if (line_exp_q.size() == 0) begin
          $display("%0t: result beat %h arrived with nothing expected", $time,
                   m_axis_tdata);
          mismatch_cnt_o++;
        end else begin
          exp_r = line_exp_q.pop_front();
          check_field("scl_level", exp_r.scl_level, got_r.scl_level);
          check_field("sda_out", exp_r.sda_out, got_r.sda_out);
          check_field("sda_enable", exp_r.sda_enable, got_r.sda_enable);
          check_field("busy_res", exp_r.busy_res, got_r.busy_res);
          check_field("done_res", exp_r.done_res, got_r.done_res);
          check_field("rx_byte", exp_r.rx_byte, got_r.rx_byte);
          check_field("nack", exp_r.nack, got_r.nack);
        end
      end
      lines_pending_o = line_exp_q.size();
    end
  end

endmodule

@@ tb/i2c_bit_level_master_tb.sv @@
// ----------------------------------------------------------------------------
// I2C bit-level master testbench
// Drives tick beats into the bit-level master: directed commands at the reset
// settings, zero and longer tick counts, then random bus transactions
// under changing settings, with random gaps on the tick side and random
// stalls on the result side. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb;
  import i2cbm_pkg::*;

  // Function codes the block does not know; they must be ignored.
  localparam logic [2:0] FuncUnusedA = 3'd6;
  localparam logic [2:0] FuncUnusedB = 3'd7;

  localparam int unsigned RandTicks = 600;
  localparam int unsigned StallLimit = 1000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SDataW-1:0]   s_axis_tdata;
  logic [SUserW-1:0]   s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [MDataW-1:0]   m_axis_tdata;

  int                  mismatch_cnt;
  int                  lines_pending;
  logic                seq_busy;
  logic                idle_on;
  int unsigned         ticks_sent;
  int unsigned         quiet_cycles;

  i2c_bit_level_master i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  i2c_bit_level_master_chk i_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_cnt_o  (mismatch_cnt),
    .lines_pending_o (lines_pending),
    .seq_busy_o      (seq_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Any cycle in which neither stream moves a beat counts toward a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("i2c_bit_level_master verification failed");
        $finish;
      end
    end
  end

  // Result side: random stall before each beat, unless idling is off.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  function automatic logic draw_sda(input int unsigned one_pct);
    return ($urandom_range(0, 99) < one_pct);
  endfunction

  // Sends one tick beat; called and returning at a falling edge.
  task automatic send_tick(input logic cmd_valid, input logic [2:0] func,
                           input logic [7:0] tx, input logic ack_lvl,
                           input logic sda_lvl);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, sda_lvl, ack_lvl, tx};
    s_axis_tuser  = {func, cmd_valid};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Issues one command and keeps ticking until the sequencer is idle again.
  // Filler ticks carry random commands, which a busy block must ignore.
  task automatic run_cmd(input logic [2:0] func, input logic [7:0] tx,
                         input logic ack_lvl, input int unsigned one_pct);
    send_tick(1'b1, func, tx, ack_lvl, draw_sda(one_pct));
    while (seq_busy) begin
      send_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)),
                8'($urandom), 1'($urandom), draw_sda(one_pct));
    end
  endtask

  // Lets every result drain, then pauses before the next step.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (lines_pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_cfg(input logic [15:0] half, input logic [15:0] setup,
                         input logic [7:0] retries);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_HALF_PERIOD;
    cfg_wdata_i = half;
    @(negedge clk_i);
    cfg_idx_i   = CFG_SETUP;
    cfg_wdata_i = setup;
    @(negedge clk_i);
    cfg_idx_i   = CFG_ACK_RETRIES;
    cfg_wdata_i = {8'd0, retries};
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // A bus transaction: start, address with ack, one to three data bytes, stop.
  task automatic run_transaction();
    int nbytes;
    nbytes = $urandom_range(1, 3);
    run_cmd(FUNC_START, 8'($urandom), 1'($urandom), 50);
    run_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom), 50);
    run_cmd(FUNC_WAIT_ACK, 8'($urandom), 1'($urandom), $urandom_range(0, 40));
    repeat (nbytes) begin
      if ($urandom_range(0, 1) == 0) begin
        run_cmd(FUNC_READ, 8'($urandom), 1'($urandom), 50);
        run_cmd(FUNC_SEND_ACK, 8'($urandom), 1'($urandom), 50);
      end else begin
        run_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom), 50);
        run_cmd(FUNC_WAIT_ACK, 8'($urandom), 1'($urandom), $urandom_range(0, 100));
      end
    end
    run_cmd(FUNC_STOP, 8'($urandom), 1'($urandom), 50);
  endtask

  initial begin
    int unsigned rand_base;
    logic [15:0] half;
    logic [15:0] setup;
    logic [7:0]  retries;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_HALF_PERIOD;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    idle_on       = 1'b1;
    ticks_sent    = 0;
    quiet_cycles  = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Every command at the reset settings, with data and ack extremes.
    run_cmd(FUNC_START, 8'h00, 1'b0, 50);
    run_cmd(FUNC_WRITE, 8'h00, 1'b0, 50);
    run_cmd(FUNC_WRITE, 8'hFF, 1'b1, 50);
    run_cmd(FUNC_WRITE, 8'hA5, 1'b0, 50);
    run_cmd(FUNC_READ, 8'h00, 1'b0, 100);
    run_cmd(FUNC_READ, 8'hFF, 1'b1, 0);
    run_cmd(FUNC_READ, 8'h3C, 1'b0, 50);
    run_cmd(FUNC_SEND_ACK, 8'h00, 1'b0, 50);
    run_cmd(FUNC_SEND_ACK, 8'hFF, 1'b1, 50);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 0);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 100);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 70);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, 50);
    // Unknown codes and ticks without a command leave the block idle.
    send_tick(1'b1, FuncUnusedA, 8'h5A, 1'b1, 1'b1);
    send_tick(1'b1, FuncUnusedB, 8'hA5, 1'b0, 1'b0);
    send_tick(1'b0, FUNC_START, 8'hFF, 1'b1, 1'b0);

    // Zero tick counts act as one; zero retries time out on the first poll.
    drain_results();
    set_cfg(16'd0, 16'd0, 8'd0);
    run_cmd(FUNC_START, 8'h00, 1'b0, 50);
    run_cmd(FUNC_WRITE, 8'($urandom), 1'b0, 50);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 100);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 0);
    run_cmd(FUNC_READ, 8'h00, 1'b0, 50);
    run_cmd(FUNC_SEND_ACK, 8'h00, 1'b1, 50);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, 50);

    // Longer counts run here without any idling.
    drain_results();
    idle_on = 1'b0;
    set_cfg(16'd40, 16'd1, 8'd1);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, 50);
    drain_results();
    set_cfg(16'd1, 16'd12, 8'd20);
    run_cmd(FUNC_WRITE, 8'h81, 1'b0, 50);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 100);
    drain_results();
    idle_on = 1'b1;

    // Random part: mostly well-formed transactions, some loose commands.
    rand_base = ticks_sent;
    while (ticks_sent - rand_base < RandTicks) begin
      drain_results();
      half    = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
      setup   = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      retries = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
      set_cfg(half, setup, retries);
      idle_on = ($urandom_range(0, 4) != 0);
      repeat (3) begin
        if ($urandom_range(0, 3) != 0) begin
          run_transaction();
        end else begin
          run_cmd(3'($urandom_range(0, 5)), 8'($urandom), 1'($urandom),
                  $urandom_range(0, 100));
        end
        if ($urandom_range(0, 2) == 0) begin
          send_tick(1'($urandom), 3'($urandom_range(6, 7)), 8'($urandom),
                    1'($urandom), 1'($urandom));
        end
      end
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0 && lines_pending == 0) begin
      $display("i2c_bit_level_master verification clean");
    end else begin
      $display("i2c_bit_level_master verification failed");
    end
    $finish;
  end

endmodule
